// ----- sv/mas_pkg.sv -----
// mas_pkg: shared constants, register indexes and sequencer states
// for the motion activity segmenter; no dependencies
package mas_pkg;

	localparam int TIME_BITS  = 40;
	localparam int COUNT_BITS = 24;
	localparam int SEG_BITS   = 20;
	localparam int LEVEL_BITS = 16;
	localparam int MOTION_BITS = 16;
	localparam int SUM_BITS   = 40;
	localparam int TOTAL_BITS = 36;
	localparam int GAP_BITS   = 24;
	localparam int CFG_BITS   = 24;
	localparam int IDX_BITS   = 2;
	localparam int NUM_BITS   = SUM_BITS + LEVEL_BITS;
	localparam int DEN_BITS   = COUNT_BITS + MOTION_BITS;
	localparam int CNT_BITS   = $clog2(LEVEL_BITS);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [SEG_BITS-1:0]   SEG_MAX   = '1;
	localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

	localparam logic [MOTION_BITS-1:0] THRESHOLD_RESET = 16'd512;
	localparam logic [MOTION_BITS-1:0] NORM_RESET      = 16'd3072;
	localparam logic [GAP_BITS-1:0]    GAP_RESET       = 24'd120000;

	// register indexes
	localparam logic [IDX_BITS-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_NORM      = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_GAP       = 2'd2;

	// input operations and result kinds
	localparam logic OP_FRAME     = 1'b0;
	localparam logic OP_END       = 1'b1;
	localparam logic KIND_SEGMENT = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_MEAN,
		S_CHECK,
		S_DIV,
		S_EMIT_SEG,
		S_EMIT_SUM
	} state_t;

endpackage

// ----- sv/motion_activity_segmenter_top.sv -----
// motion_activity_segmenter_top: segments frames by motion level, reports
// segment levels and an end-of-stream summary; depends on mas_pkg
//
// channel | direction | signals
// --------+-----------+-----------------------------------------------------
// in      | request   | in_valid, in_ready, operation, timestamp_us, motion
// out     | result    | out_valid, out_ready, kind, start_us, end_us, level,
//         |           | segment_count, last
// cfg     | write     | cfg_we, cfg_index, cfg_data
//
// a frame that opens or extends a segment is handled in the idle state; a
// frame that closes a segment runs the multiply, the range check, 16 divider
// steps (skipped when the range check clamps) and the emit; an end request
// with an open segment runs the single restoring divider once for the level
// and once for the mean. in_ready is high only while the sequencer is idle;
// an emit state waits while the output register still holds an untaken
// result. reset restores register defaults and clears all stream state.
module motion_activity_segmenter_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  operation,
	input  logic [mas_pkg::TIME_BITS-1:0]         timestamp_us,
	input  logic [mas_pkg::MOTION_BITS-1:0]       motion,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  kind,
	output logic [mas_pkg::TIME_BITS-1:0]         start_us,
	output logic [mas_pkg::TIME_BITS-1:0]         end_us,
	output logic [mas_pkg::LEVEL_BITS-1:0]        level,
	output logic [mas_pkg::SEG_BITS-1:0]          segment_count,
	output logic                                  last,
	input  logic                                  cfg_we,
	input  logic [mas_pkg::IDX_BITS-1:0]          cfg_index,
	input  logic [mas_pkg::CFG_BITS-1:0]          cfg_data
);

	mas_pkg::state_t state_q, state_d;

	// configuration registers
	logic [mas_pkg::MOTION_BITS-1:0] threshold_q;
	logic [mas_pkg::MOTION_BITS-1:0] norm_q;
	logic [mas_pkg::GAP_BITS-1:0]    gap_q;

	// stream state
	logic                            seg_open_q;
	logic [mas_pkg::TIME_BITS-1:0]   seg_start_q;
	logic [mas_pkg::TIME_BITS-1:0]   seg_end_q;
	logic [mas_pkg::SUM_BITS-1:0]    sum_q;
	logic [mas_pkg::COUNT_BITS-1:0]  count_q;
	logic [mas_pkg::TOTAL_BITS-1:0]  total_q;
	logic [mas_pkg::SEG_BITS-1:0]    seen_q;

	// latched request
	logic                            end_op_q;
	logic                            reopen_q;
	logic [mas_pkg::TIME_BITS-1:0]   ts_q;
	logic [mas_pkg::MOTION_BITS-1:0] motion_q;

	// shared divider
	logic                            mean_q;
	logic [mas_pkg::NUM_BITS-1:0]    num_q;
	logic [mas_pkg::DEN_BITS-1:0]    den_q;
	logic [mas_pkg::DEN_BITS-1:0]    rem_q;
	logic [mas_pkg::LEVEL_BITS-1:0]  lo_q;
	logic [mas_pkg::LEVEL_BITS-1:0]  quo_q;
	logic [mas_pkg::CNT_BITS-1:0]    cnt_q;

	// output register
	logic                            out_valid_q;
	logic                            kind_q;
	logic [mas_pkg::TIME_BITS-1:0]   start_q;
	logic [mas_pkg::TIME_BITS-1:0]   end_q;
	logic [mas_pkg::LEVEL_BITS-1:0]  level_q;
	logic [mas_pkg::SEG_BITS-1:0]    segcnt_q;
	logic                            last_q;

	// combinational helpers
	logic                            active;
	logic [mas_pkg::TIME_BITS-1:0]   ts_diff;
	logic                            gap_break;
	logic                            out_free;
	logic                            emit_go;
	logic                            clamp;
	logic [mas_pkg::DEN_BITS:0]      trial;
	logic                            trial_ge;
	logic [mas_pkg::MOTION_BITS-1:0] norm_eff;
	logic [mas_pkg::DEN_BITS-1:0]    den_prod;
	logic                            seen_inc;
	logic [mas_pkg::SEG_BITS-1:0]    seen_next;
	logic [mas_pkg::TOTAL_BITS:0]    total_sum;
	logic [mas_pkg::TOTAL_BITS-1:0]  total_next;
	logic [mas_pkg::SUM_BITS:0]      sum_ext;

	// request classification
	assign active    = motion >= threshold_q;
	assign ts_diff   = timestamp_us - seg_end_q;
	assign gap_break = (timestamp_us > seg_end_q) &&
		(ts_diff > mas_pkg::TIME_BITS'(gap_q));
	assign out_free  = !out_valid_q || out_ready;

	// an emit state loads the output register this cycle
	assign emit_go = ((state_q == mas_pkg::S_EMIT_SEG) ||
		(state_q == mas_pkg::S_EMIT_SUM)) && out_free;

	// divider step and range check
	assign clamp    = num_q[mas_pkg::NUM_BITS-1 -: mas_pkg::DEN_BITS] >= den_q;
	assign trial    = {rem_q, lo_q[mas_pkg::LEVEL_BITS-1]};
	assign trial_ge = trial >= (mas_pkg::DEN_BITS+1)'(den_q);

	// level denominator
	assign norm_eff = (norm_q == '0) ? mas_pkg::MOTION_BITS'(1) : norm_q;
	assign den_prod = mas_pkg::DEN_BITS'(count_q) * mas_pkg::DEN_BITS'(norm_eff);

	// segment bookkeeping on close
	assign seen_inc   = seen_q != mas_pkg::SEG_MAX;
	assign seen_next  = seen_q + mas_pkg::SEG_BITS'(seen_inc);
	assign total_sum  = (mas_pkg::TOTAL_BITS+1)'(total_q) +
		(mas_pkg::TOTAL_BITS+1)'(quo_q);
	assign total_next = total_sum[mas_pkg::TOTAL_BITS] ? mas_pkg::TOTAL_MAX :
		total_sum[mas_pkg::TOTAL_BITS-1:0];
	assign sum_ext    = (mas_pkg::SUM_BITS+1)'(sum_q) +
		(mas_pkg::SUM_BITS+1)'(motion);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mas_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			mas_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (operation == mas_pkg::OP_END) begin
						state_d = seg_open_q ? mas_pkg::S_MUL : mas_pkg::S_MEAN;
					end else if (seg_open_q && (!active || gap_break)) begin
						state_d = mas_pkg::S_MUL;
					end
				end
			end
			mas_pkg::S_MUL: begin
				state_d = mas_pkg::S_CHECK;
			end
			mas_pkg::S_MEAN: begin
				state_d = (seen_q == '0) ? mas_pkg::S_EMIT_SUM : mas_pkg::S_CHECK;
			end
			mas_pkg::S_CHECK: begin
				if (clamp) begin
					state_d = mean_q ? mas_pkg::S_EMIT_SUM : mas_pkg::S_EMIT_SEG;
				end else begin
					state_d = mas_pkg::S_DIV;
				end
			end
			mas_pkg::S_DIV: begin
				if (cnt_q == '0) begin
					state_d = mean_q ? mas_pkg::S_EMIT_SUM : mas_pkg::S_EMIT_SEG;
				end
			end
			mas_pkg::S_EMIT_SEG: begin
				if (out_free) begin
					state_d = end_op_q ? mas_pkg::S_MEAN : mas_pkg::S_IDLE;
				end
			end
			mas_pkg::S_EMIT_SUM: begin
				if (out_free) begin
					state_d = mas_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mas_pkg::S_IDLE;
			end
		endcase
	end

	// datapath, stream state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= mas_pkg::THRESHOLD_RESET;
			norm_q      <= mas_pkg::NORM_RESET;
			gap_q       <= mas_pkg::GAP_RESET;
			seg_open_q  <= 1'b0;
			seg_start_q <= '0;
			seg_end_q   <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			total_q     <= '0;
			seen_q      <= '0;
			end_op_q    <= 1'b0;
			reopen_q    <= 1'b0;
			mean_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					mas_pkg::REG_THRESHOLD: threshold_q <= cfg_data[mas_pkg::MOTION_BITS-1:0];
					mas_pkg::REG_NORM:      norm_q      <= cfg_data[mas_pkg::MOTION_BITS-1:0];
					mas_pkg::REG_GAP:       gap_q       <= cfg_data[mas_pkg::GAP_BITS-1:0];
					default: ;
				endcase
			end

			// result loaded or taken
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				mas_pkg::S_IDLE: begin
					if (in_valid) begin
						end_op_q <= operation;
						ts_q     <= timestamp_us;
						motion_q <= motion;
						reopen_q <= (operation == mas_pkg::OP_FRAME) && active &&
							seg_open_q && gap_break;
						if (operation == mas_pkg::OP_FRAME && active) begin
							if (!seg_open_q) begin
								// start a segment
								seg_open_q  <= 1'b1;
								seg_start_q <= timestamp_us;
								seg_end_q   <= timestamp_us;
								sum_q       <= mas_pkg::SUM_BITS'(motion);
								count_q     <= mas_pkg::COUNT_BITS'(1);
							end else if (!gap_break) begin
								// extend the open segment
								seg_end_q <= timestamp_us;
								if (count_q != mas_pkg::COUNT_MAX) begin
									count_q <= count_q + mas_pkg::COUNT_BITS'(1);
									sum_q   <= sum_ext[mas_pkg::SUM_BITS] ? mas_pkg::SUM_MAX :
										sum_ext[mas_pkg::SUM_BITS-1:0];
								end
							end
						end
					end
				end
				mas_pkg::S_MUL: begin
					// numerator sum*65535, denominator count*norm
					mean_q <= 1'b0;
					den_q  <= den_prod;
					num_q  <= {sum_q, mas_pkg::LEVEL_BITS'(0)} -
						mas_pkg::NUM_BITS'(sum_q);
				end
				mas_pkg::S_MEAN: begin
					mean_q <= 1'b1;
					quo_q  <= '0;
					den_q  <= mas_pkg::DEN_BITS'(seen_q);
					num_q  <= mas_pkg::NUM_BITS'(total_q);
				end
				mas_pkg::S_CHECK: begin
					if (clamp) begin
						quo_q <= '1;
					end else begin
						rem_q <= num_q[mas_pkg::NUM_BITS-1 -: mas_pkg::DEN_BITS];
						lo_q  <= num_q[mas_pkg::LEVEL_BITS-1:0];
						cnt_q <= '1;
					end
				end
				mas_pkg::S_DIV: begin
					// one restoring step per cycle
					rem_q <= trial_ge ? mas_pkg::DEN_BITS'(trial - (mas_pkg::DEN_BITS+1)'(den_q)) :
						trial[mas_pkg::DEN_BITS-1:0];
					lo_q  <= {lo_q[mas_pkg::LEVEL_BITS-2:0], 1'b0};
					quo_q <= {quo_q[mas_pkg::LEVEL_BITS-2:0], trial_ge};
					cnt_q <= cnt_q - mas_pkg::CNT_BITS'(1);
				end
				mas_pkg::S_EMIT_SEG: begin
					if (out_free) begin
						kind_q      <= mas_pkg::KIND_SEGMENT;
						start_q     <= seg_start_q;
						end_q       <= seg_end_q;
						level_q     <= quo_q;
						segcnt_q    <= seen_next;
						last_q      <= !end_op_q;
						seen_q      <= seen_next;
						if (seen_inc) begin
							total_q <= total_next;
						end
						if (reopen_q) begin
							seg_open_q  <= 1'b1;
							seg_start_q <= ts_q;
							seg_end_q   <= ts_q;
							sum_q       <= mas_pkg::SUM_BITS'(motion_q);
							count_q     <= mas_pkg::COUNT_BITS'(1);
						end else begin
							seg_open_q  <= 1'b0;
							seg_start_q <= '0;
							seg_end_q   <= '0;
							sum_q       <= '0;
							count_q     <= '0;
						end
					end
				end
				mas_pkg::S_EMIT_SUM: begin
					if (out_free) begin
						kind_q      <= mas_pkg::KIND_SUMMARY;
						start_q     <= '0;
						end_q       <= '0;
						level_q     <= quo_q;
						segcnt_q    <= seen_q;
						last_q      <= 1'b1;
						seg_open_q  <= 1'b0;
						seg_start_q <= '0;
						seg_end_q   <= '0;
						sum_q       <= '0;
						count_q     <= '0;
						total_q     <= '0;
						seen_q      <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// output ports
	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign start_us      = start_q;
	assign end_us        = end_q;
	assign level         = level_q;
	assign segment_count = segcnt_q;
	assign last          = last_q;

	// summary results close the request and carry no times
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == mas_pkg::KIND_SUMMARY |-> last && start_us == '0 && end_us == '0)
		else $error("summary result malformed");

	// a reported segment is always counted
	a_segment_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == mas_pkg::KIND_SEGMENT |-> segment_count != '0)
		else $error("segment reported with zero count");

	// the divider never runs with a zero denominator
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mas_pkg::S_DIV |-> den_q != '0)
		else $error("divider running on zero denominator");

	// an open segment always holds at least one frame
	a_open_count: assert property (@(posedge clk) disable iff (!arst_n)
		seg_open_q |-> count_q != '0)
		else $error("open segment with zero frame count");

endmodule

// ----- tb/motion_activity_segmenter_tb.sv -----
// motion_activity_segmenter_tb: self-checking bench for motion_activity_segmenter_top
// a scoreboard class predicts closed segments and stream summaries from accepted requests
// depends on mas_pkg and the segmenter rtl
module testbench;
	import mas_pkg::*;

	localparam int RANDOM_ITEMS  = 1525;
	localparam int PHASES        = 6;
	localparam int SETTLE_CYCLES = 60;
	localparam int STALL_LIMIT   = 3000;
	localparam int IDLE_PCT      = 31;
	localparam logic [IDX_BITS-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic                  kind;
		logic [TIME_BITS-1:0]  start_us;
		logic [TIME_BITS-1:0]  end_us;
		logic [LEVEL_BITS-1:0] level;
		logic [SEG_BITS-1:0]   segment_count;
		logic                  last;
	} seg_result_t;

	// segment tracker and queue of segment and summary results still owed
	class segment_scoreboard;
		logic [MOTION_BITS-1:0] threshold;
		logic [MOTION_BITS-1:0] norm;
		logic [GAP_BITS-1:0]    gap;
		bit                     seg_open;
		logic [TIME_BITS-1:0]   seg_first;
		logic [TIME_BITS-1:0]   seg_last;
		logic [SUM_BITS-1:0]    sum;
		logic [COUNT_BITS-1:0]  frames;
		logic [TOTAL_BITS-1:0]  total;
		logic [SEG_BITS-1:0]    seen;
		seg_result_t            owed_q[$];
		int                     errors;

		function new();
			threshold = THRESHOLD_RESET;
			norm = NORM_RESET;
			gap = GAP_RESET;
			errors = 0;
			total = '0;
			seen = '0;
			clear_segment();
		endfunction

		function void set_register(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
			case (idx)
				REG_THRESHOLD: threshold = data[MOTION_BITS-1:0];
				REG_NORM: norm = data[MOTION_BITS-1:0];
				REG_GAP: gap = data[GAP_BITS-1:0];
				default: ;
			endcase
		endfunction

		function void clear_segment();
			seg_open = 1'b0;
			seg_first = '0;
			seg_last = '0;
			sum = '0;
			frames = '0;
		endfunction

		function void open_segment(logic [TIME_BITS-1:0] ts, logic [MOTION_BITS-1:0] m);
			seg_open = 1'b1;
			seg_first = ts;
			seg_last = ts;
			sum = SUM_BITS'(m);
			frames = COUNT_BITS'(1);
		endfunction

		// level = sum * 65535 / (frames * norm), clipped to full scale
		function void close_segment(logic is_last);
			logic [63:0] divisor;
			logic [63:0] quotient;
			logic [63:0] running;
			seg_result_t r;
			if (!seg_open)
				return;
			divisor = (norm == 0) ? 64'd1 : 64'(norm);
			divisor = 64'(frames) * divisor;
			if (divisor == 0)
				divisor = 64'd1;
			quotient = (64'(sum) * 64'd65535) / divisor;
			if (quotient > 64'd65535)
				quotient = 64'd65535;
			// segment count saturated: level no longer accumulates
			if (seen < SEG_MAX) begin
				seen = seen + SEG_BITS'(1);
				running = 64'(total) + quotient;
				total = (running > 64'(TOTAL_MAX)) ? TOTAL_MAX : running[TOTAL_BITS-1:0];
			end
			r.kind = KIND_SEGMENT;
			r.start_us = seg_first;
			r.end_us = seg_last;
			r.level = quotient[LEVEL_BITS-1:0];
			r.segment_count = seen;
			r.last = is_last;
			owed_q.push_back(r);
			clear_segment();
		endfunction

		function void note_request(logic op, logic [TIME_BITS-1:0] ts,
				logic [MOTION_BITS-1:0] m);
			seg_result_t r;
			logic [SUM_BITS:0] grown;
			if (op == OP_END) begin
				// flush, then summary with the mean level
				close_segment(1'b0);
				r.kind = KIND_SUMMARY;
				r.start_us = '0;
				r.end_us = '0;
				r.level = (seen == 0) ? '0 : LEVEL_BITS'(total / TOTAL_BITS'(seen));
				r.segment_count = seen;
				r.last = 1'b1;
				owed_q.push_back(r);
				clear_segment();
				total = '0;
				seen = '0;
			end else if (m < threshold) begin
				close_segment(1'b1);
			end else if (!seg_open) begin
				open_segment(ts, m);
			end else if (ts > seg_last && ts - seg_last > TIME_BITS'(gap)) begin
				close_segment(1'b1);
				open_segment(ts, m);
			end else begin
				// extend; a backwards time still moves the end
				seg_last = ts;
				if (frames < COUNT_MAX) begin
					frames = frames + COUNT_BITS'(1);
					grown = {1'b0, sum} + (SUM_BITS+1)'(m);
					sum = grown[SUM_BITS] ? SUM_MAX : grown[SUM_BITS-1:0];
				end
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		task report(string msg);
			if (errors < 40)
				$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(seg_result_t got);
			seg_result_t want;
			if (owed_q.size() == 0) begin
				report($sformatf("unexpected result kind %0d level %0d", got.kind, got.level));
				return;
			end
			want = owed_q.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("kind got %0d expected %0d", got.kind, want.kind));
			if (got.start_us !== want.start_us)
				report($sformatf("start_us got %h expected %h", got.start_us, want.start_us));
			if (got.end_us !== want.end_us)
				report($sformatf("end_us got %h expected %h", got.end_us, want.end_us));
			if (got.level !== want.level)
				report($sformatf("level got %0d expected %0d", got.level, want.level));
			if (got.segment_count !== want.segment_count)
				report($sformatf("segment_count got %0d expected %0d",
					got.segment_count, want.segment_count));
			if (got.last !== want.last)
				report($sformatf("last got %0d expected %0d", got.last, want.last));
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic                   operation;
	logic [TIME_BITS-1:0]   timestamp_us;
	logic [MOTION_BITS-1:0] motion;
	logic                   out_valid;
	logic                   out_ready;
	logic                   kind;
	logic [TIME_BITS-1:0]   start_us;
	logic [TIME_BITS-1:0]   end_us;
	logic [LEVEL_BITS-1:0]  level;
	logic [SEG_BITS-1:0]    segment_count;
	logic                   last;
	logic                   cfg_we;
	logic [IDX_BITS-1:0]    cfg_index;
	logic [CFG_BITS-1:0]    cfg_data;

	bit                     steady = 1'b0;
	logic [TIME_BITS-1:0]   ts_cursor = '0;
	seg_result_t            observed;
	segment_scoreboard      sb = new();

	motion_activity_segmenter_top uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side backpressure
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= arst_n && (steady || $urandom_range(99, 0) >= IDLE_PCT);
		end
	end

	// compare every taken result against the oldest owed one
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			observed.kind = kind;
			observed.start_us = start_us;
			observed.end_us = end_us;
			observed.level = level;
			observed.segment_count = segment_count;
			observed.last = last;
			sb.check_result(observed);
		end
	end

	// end the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	// present one request, with random idle cycles first
	task automatic send_request(logic op, logic [TIME_BITS-1:0] ts, logic [MOTION_BITS-1:0] m);
		@(negedge clk);
		while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		timestamp_us <= ts;
		motion <= m;
		do @(posedge clk); while (!in_ready);
		sb.note_request(op, ts, m);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_register(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly in-gap steps, some gap breaks, backwards steps and wild jumps
	function automatic logic [TIME_BITS-1:0] next_timestamp();
		int unsigned pick;
		pick = $urandom_range(99, 0);
		if (pick < 65)
			ts_cursor += TIME_BITS'($urandom_range(sb.gap, 0));
		else if (pick < 72)
			ts_cursor += TIME_BITS'(sb.gap);
		else if (pick < 84)
			ts_cursor += TIME_BITS'(sb.gap) + TIME_BITS'($urandom_range(50000, 0)) +
				TIME_BITS'(1);
		else if (pick < 90)
			ts_cursor -= TIME_BITS'($urandom_range(5000, 1));
		else
			ts_cursor = TIME_BITS'({$urandom, $urandom});
		return ts_cursor;
	endfunction

	// motion at or just above the threshold, below it, or anywhere
	function automatic logic [MOTION_BITS-1:0] pick_motion();
		int unsigned pick;
		int unsigned above;
		pick = $urandom_range(99, 0);
		if (pick < 50) begin
			above = sb.threshold + $urandom_range(1500, 0);
			return (above > 65535) ? 16'hFFFF : 16'(above);
		end
		if (pick < 75 && sb.threshold != 0)
			return 16'($urandom_range(sb.threshold - 1, 0));
		return 16'($urandom);
	endfunction

	task automatic configure_phase(int p);
		logic [CFG_BITS-1:0] thr;
		logic [CFG_BITS-1:0] nrm;
		logic [CFG_BITS-1:0] gp;
		case (p)
			0: begin
				thr = THRESHOLD_RESET;
				nrm = NORM_RESET;
				gp = GAP_RESET;
			end
			1: begin
				thr = CFG_BITS'($urandom_range(4000, 0));
				nrm = CFG_BITS'($urandom_range(8000, 1));
				gp = CFG_BITS'($urandom_range(200000, 1000));
			end
			2: begin
				thr = '0;
				nrm = 24'd1;
				gp = '0;
			end
			3: begin
				thr = 24'hFFFF;
				nrm = 24'hFFFF;
				gp = 24'hFF_FFFF;
			end
			4: begin
				thr = CFG_BITS'($urandom_range(65535, 0));
				nrm = '0;
				gp = CFG_BITS'($urandom_range(24'hFF_FFFF, 0));
			end
			default: begin
				thr = CFG_BITS'($urandom_range(2048, 256));
				nrm = CFG_BITS'($urandom_range(65535, 1000));
				gp = CFG_BITS'($urandom_range(100000, 0));
			end
		endcase
		write_register(REG_THRESHOLD, thr);
		write_register(REG_NORM, nrm);
		write_register(REG_GAP, gp);
	endtask

	task automatic run_directed();
		// reset settings: empty summary, then each side of the gap rule
		send_request(OP_END, 40'h12_3456_789A, 16'hFFFF);
		send_request(OP_FRAME, 40'd1000, 16'd512);
		send_request(OP_FRAME, 40'd34333, 16'hFFFF);
		send_request(OP_FRAME, 40'd20000, 16'd600);
		send_request(OP_FRAME, 40'd140000, 16'd700);
		send_request(OP_FRAME, 40'd260001, 16'd800);
		send_request(OP_FRAME, 40'd260100, 16'd511);
		send_request(OP_FRAME, 40'd260200, 16'd0);
		send_request(OP_FRAME, '1, 16'hFFFF);
		send_request(OP_END, '0, '0);
		wait_drained();

		// zero threshold and gap, norm of zero acts as one, unused index ignored
		write_register(REG_THRESHOLD, '0);
		write_register(REG_NORM, '0);
		write_register(REG_GAP, '0);
		write_register(REG_UNUSED, '1);
		send_request(OP_FRAME, 40'd5, 16'd0);
		send_request(OP_FRAME, 40'd5, 16'd0);
		send_request(OP_FRAME, 40'd6, 16'hFFFF);
		send_request(OP_FRAME, 40'd6, 16'hFFFF);
		send_request(OP_FRAME, 40'd3, 16'd7);
		send_request(OP_END, '1, 16'hFFFF);
		wait_drained();

		// top threshold, norm and gap
		write_register(REG_THRESHOLD, 24'hFFFF);
		write_register(REG_NORM, 24'hFFFF);
		write_register(REG_GAP, 24'hFF_FFFF);
		send_request(OP_FRAME, 40'd0, 16'hFFFE);
		send_request(OP_FRAME, 40'd0, 16'hFFFF);
		send_request(OP_FRAME, 40'hFF_FFFF, 16'hFFFF);
		send_request(OP_FRAME, 40'h200_0000, 16'hFFFF);
		send_request(OP_FRAME, 40'h200_0001, 16'hFFFE);
		send_request(OP_END, '0, '0);
	endtask

	task automatic run_random();
		int per_phase;
		int count;
		int done;
		per_phase = RANDOM_ITEMS / PHASES;
		done = 0;
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			configure_phase(p);
			count = (p == PHASES - 1) ? per_phase + RANDOM_ITEMS % PHASES : per_phase;
			for (int i = 0; i < count; i++) begin
				steady = (done >= 600 && done < 900);
				// hold off mid-phase until every owed result is out
				if (p % 2 == 1 && i == count / 2)
					wait_drained();
				if ($urandom_range(99, 0) < 3)
					send_request(OP_END, TIME_BITS'({$urandom, $urandom}), 16'($urandom));
				else
					send_request(OP_FRAME, next_timestamp(), pick_motion());
				done++;
			end
		end
		steady = 1'b0;
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_FRAME;
		timestamp_us = '0;
		motion = '0;
		cfg_we = 1'b0;
		cfg_index = REG_THRESHOLD;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random();
		wait_drained();
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ----- motion_activity_segmenter_top.f -----
sv/mas_pkg.sv
sv/motion_activity_segmenter_top.sv
tb/motion_activity_segmenter_tb.sv
